>>> rtl/core/ihte_pkg.sv
// Package for the interval histogram tempo estimator.
// Holds word types, codes, fixed widths and arithmetic constants.
// No dependencies; every other file of the block but ihte_stream_if uses it.
`default_nettype none

package ihte_pkg;

	// Default histogram depth, one bin per millisecond of period.
	localparam int HIST_BINS_DEF = 2000;

	// Fixed field widths.
	localparam int ONSET_W   = 32;
	localparam int TEMPO_W   = 23;
	localparam int STATUS_W  = 2;
	localparam int BPM_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int CNT_W     = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM = 1'b1;

	// Register reset values.
	localparam logic [BPM_W-1:0] MIN_BPM_RST = 9'd60;
	localparam logic [BPM_W-1:0] MAX_BPM_RST = 9'd200;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FEW_ONSETS  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_INTERVAL = 2'd2;

	// Onset counter saturates once four onsets are seen.
	localparam int COUNT_W = 3;
	localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

	// Valid gap window in microseconds (both bounds exclusive).
	localparam logic [ONSET_W-1:0] GAP_LOW_US  = 32'd200000;
	localparam logic [ONSET_W-1:0] GAP_HIGH_US = 32'd2000000;
	localparam int GAP_W = 21;

	// Microseconds to milliseconds: multiply by ceil(2^30 / 1000), keep bits 30 and up.
	// Exact for every gap below about six million.
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] MS_RECIP = 21'd1073742;
	localparam int MS_W = 11;

	// Spread of one gap: nine taps around the center bin, weights 2..10..2.
	localparam int TAP_W = 4;
	localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;
	localparam logic [TAP_W-1:0] TAP_CENTER = 4'd4;

	// Period search.
	localparam int SBIN_W  = 16;
	localparam int SCORE_W = 17;

	// Tempo conversion constants.
	localparam int MS_PER_MIN     = 60000;
	localparam int HALF_TIME_LOW  = 62;
	localparam int HALF_TIME_HIGH = 68;
	localparam int BPM_CEILING    = 200;

	// Divider dividend width, the numerator for the period limits and the Q8 tempo numerators.
	localparam int NUM_W = 25;
	localparam logic [NUM_W-1:0] NUM_MS_PER_MIN = 25'd60000;
	localparam logic [NUM_W-1:0] NUM_HALF_Q8    = 25'd7680000;
	localparam logic [NUM_W-1:0] NUM_BASE_Q8    = 25'd15360000;
	localparam logic [NUM_W-1:0] NUM_DOUBLE_Q8  = 25'd30720000;

	// Input word.
	typedef struct packed {
		logic [ONSET_W-1:0] onset_time_us;
		logic               last_onset;
	} onset_word_t;

	// Result word.
	typedef struct packed {
		logic [TEMPO_W-1:0]  tempo_bpm_q8;
		logic [STATUS_W-1:0] status;
	} tempo_word_t;

	// Divider status toward the controller.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BIN,
		ST_ACC,
		ST_ACC_END,
		ST_DECIDE,
		ST_DIV_LO,
		ST_DIV_HI,
		ST_SEARCH,
		ST_SEARCH_END,
		ST_DIV_TEMPO,
		ST_EMIT
	} state_t;

	// Read phase of one candidate bin during the search.
	typedef enum logic [1:0] {
		PH_SELF,
		PH_HALF,
		PH_DOUBLE
	} phase_t;

endpackage

`default_nettype wire

>>> rtl/core/ihte_stream_if.sv
// Valid/ready stream interface carrying one word per handshake.
// The word type is a parameter; the block uses the word types of ihte_pkg.
`default_nettype none

interface ihte_stream_if #(
	parameter type word_t = logic
) ();

	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

>>> rtl/core/ihte_div.sv
// Restoring divider, one quotient bit per cycle, shared by the estimator.
// Depends on ihte_pkg for the dividend width and the status struct.
`default_nettype none

module ihte_div #(
	parameter int DEN_W = 11
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [ihte_pkg::NUM_W-1:0]    dividend,
	input  wire [DEN_W-1:0]              divisor,
	output ihte_pkg::div_stat_t          stat,
	output logic [ihte_pkg::NUM_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(ihte_pkg::NUM_W + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [DEN_W-1:0]           den_q;
	logic [DEN_W-1:0]           rem_q;
	logic [ihte_pkg::NUM_W-1:0] quo_q;

	logic [DEN_W:0]             rem_sh;
	logic [DEN_W:0]             rem_sub;
	logic                       fits;

	// One restoring step: shift in the next dividend bit, subtract when it fits.
	always_comb begin
		rem_sh  = {rem_q, quo_q[ihte_pkg::NUM_W-1]};
		fits    = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	// Control: run for one step per dividend bit, pulse done at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ihte_pkg::NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[ihte_pkg::NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/interval_histogram_tempo_estimator_unit.sv
// Top level of the inter-onset interval histogram tempo estimator.
// Depends on ihte_pkg, ihte_stream_if and the shared divider ihte_div.
//
// Usage:
//   onset carries one word per onset time (microseconds) with a last flag;
//   result carries one word (Q8 tempo and status) for each word marked last.
//   min_bpm and max_bpm are written through cfg_wr_en, cfg_index and cfg_data;
//   the user does so only while the block is idle; the block does not enforce it.
// Flow:
//   A word that forms a gap between 200 ms and 2 s is accepted, converted to
//   milliseconds, then spread by nine read-modify-writes of the histogram
//   through its single read and single write port, plus a write-back step.
//   Other words need only the accept. A last word adds up to three divisions
//   and a search at three memory reads per candidate period bin. After each
//   result the histogram is zeroed, one bin per cycle, and no word is accepted
//   meanwhile.
// Reset:
//   Reset restores the register defaults (60 and 200 BPM) and starts the same
//   clearing pass.
// Stall:
//   The result sits in an output register; a stalled receiver holds it there
//   and the block waits before it produces the following result.
`default_nettype none

module interval_histogram_tempo_estimator_unit #(
	parameter int HIST_BINS = ihte_pkg::HIST_BINS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_wr_en,
	input  wire [ihte_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [ihte_pkg::BPM_W-1:0]        cfg_data,
	ihte_stream_if.sink                      onset,
	ihte_stream_if.source                    result
);

	localparam int BIN_W  = $clog2(HIST_BINS);
	localparam int PROD_W = BIN_W + 8;
	localparam int MUL_W  = ihte_pkg::GAP_W + ihte_pkg::RECIP_W;

	// Weight of one tap: 2, 4, 6, 8, 10, 8, 6, 4, 2.
	function automatic logic [ihte_pkg::TAP_W-1:0] tap_weight(
		input logic [ihte_pkg::TAP_W-1:0] k
	);
		logic [ihte_pkg::TAP_W-1:0] w;
		if (k <= ihte_pkg::TAP_CENTER) begin
			w = 4'd2 + {k[2:0], 1'b0};
		end else begin
			w = 4'(5'd18 - {k, 1'b0});
		end
		return w;
	endfunction

	// Controller and set state.
	ihte_pkg::state_t                  state_q, state_d;
	logic [ihte_pkg::BPM_W-1:0]        min_bpm_q, max_bpm_q;
	logic [ihte_pkg::ONSET_W-1:0]      prev_q;
	logic [ihte_pkg::COUNT_W-1:0]      count_q;
	logic                              any_q;
	logic                              last_q;
	logic [BIN_W-1:0]                  clr_q;
	logic [ihte_pkg::TAP_W-1:0]        tap_q;
	ihte_pkg::phase_t                  ph_q;

	// Working registers.
	logic [ihte_pkg::GAP_W-1:0]        gap_q;
	logic [BIN_W-1:0]                  bin_q;
	logic [ihte_pkg::SBIN_W-1:0]       sbin_q, stop_q;
	logic [ihte_pkg::SCORE_W-1:0]      acc_q, best_score_q;
	logic [BIN_W-1:0]                  best_bin_q;
	logic [ihte_pkg::TEMPO_W-1:0]      res_tempo_q;
	logic [ihte_pkg::STATUS_W-1:0]     res_status_q;
	logic                              out_valid_q;
	ihte_pkg::tempo_word_t             out_word_q;

	// Histogram memory and its pipeline.
	logic [ihte_pkg::CNT_W-1:0]        hist_mem [HIST_BINS];
	logic [ihte_pkg::CNT_W-1:0]        rd_data_q;
	logic                              acc_v_s1;
	logic [BIN_W-1:0]                  acc_addr_s1;
	logic [ihte_pkg::TAP_W-1:0]        acc_w_s1;
	logic                              srch_v_s1;
	ihte_pkg::phase_t                  srch_ph_s1;
	logic                              srch_use_s1;
	logic [BIN_W-1:0]                  srch_bin_s1;

	// Combinational signals.
	logic                              in_acc;
	logic [ihte_pkg::ONSET_W-1:0]      gap_full;
	logic                              gap_ok;
	logic [MUL_W-1:0]                  ms_prod;
	logic [BIN_W:0]                    tap_addr;
	logic                              tap_in;
	logic                              srch_go;
	logic                              dbl_in;
	logic [ihte_pkg::SCORE_W-1:0]      half_rd;
	logic [ihte_pkg::SCORE_W-1:0]      score;
	logic [ihte_pkg::CNT_W:0]          sat_sum;
	logic                              mem_re, mem_we;
	logic [BIN_W-1:0]                  mem_raddr, mem_waddr;
	logic [ihte_pkg::CNT_W-1:0]        mem_wdata;
	logic [BIN_W-1:0]                  b_eff;
	logic [PROD_W-1:0]                 p_low, p_high, p_ceil;
	logic [ihte_pkg::NUM_W-1:0]        tempo_num;
	logic [BIN_W-1:0]                  lo_bpm, hi_bpm;
	logic                              set_ok;
	logic                              slot_free;
	logic                              div_start;
	logic [ihte_pkg::NUM_W-1:0]        div_dividend;
	logic [BIN_W-1:0]                  div_divisor;
	ihte_pkg::div_stat_t               div_stat;
	logic [ihte_pkg::NUM_W-1:0]        div_quo;

	// Gap of the incoming onset and its validity.
	always_comb begin
		in_acc   = onset.valid && onset.ready;
		gap_full = onset.data.onset_time_us - prev_q;
		gap_ok   = (count_q != '0) && (onset.data.onset_time_us >= prev_q) &&
			(gap_full > ihte_pkg::GAP_LOW_US) && (gap_full < ihte_pkg::GAP_HIGH_US);
	end

	// Microseconds to whole milliseconds by reciprocal multiplication.
	assign ms_prod = gap_q * ihte_pkg::MS_RECIP;

	// Tap addresses; the center bin is at least 200, so no tap goes negative.
	always_comb begin
		tap_addr = {1'b0, bin_q} + (BIN_W+1)'(tap_q) - (BIN_W+1)'(ihte_pkg::TAP_CENTER);
		tap_in   = tap_addr < (BIN_W+1)'(HIST_BINS);
	end

	// Search loop condition and the double-period bin check.
	always_comb begin
		srch_go = (ph_q != ihte_pkg::PH_SELF) ||
			((sbin_q < stop_q) && (sbin_q < ihte_pkg::SBIN_W'(HIST_BINS)));
		dbl_in  = {sbin_q, 1'b0} < (ihte_pkg::SBIN_W+1)'(HIST_BINS);
	end

	// Score of the candidate whose last read returns this cycle.
	always_comb begin
		half_rd = ihte_pkg::SCORE_W'(rd_data_q[ihte_pkg::CNT_W-1:1]);
		score   = acc_q + (srch_use_s1 ? half_rd : '0);
		sat_sum = {1'b0, rd_data_q} + (ihte_pkg::CNT_W+1)'(acc_w_s1);
	end

	// Effective bpm limits, the tempo numerator with half-time and too-fast correction, set and slot checks.
	always_comb begin
		lo_bpm = (max_bpm_q == '0) ? BIN_W'(1) : BIN_W'(max_bpm_q);
		hi_bpm = (min_bpm_q == '0) ? BIN_W'(1) : BIN_W'(min_bpm_q);
		b_eff  = (best_bin_q == '0) ? BIN_W'(1) : best_bin_q;
		p_low  = PROD_W'(b_eff) * PROD_W'(ihte_pkg::HALF_TIME_LOW);
		p_high = PROD_W'(b_eff) * PROD_W'(ihte_pkg::HALF_TIME_HIGH);
		p_ceil = PROD_W'(b_eff) * PROD_W'(ihte_pkg::BPM_CEILING);
		if ((PROD_W'(ihte_pkg::MS_PER_MIN) >= p_low) &&
			(PROD_W'(ihte_pkg::MS_PER_MIN) <= p_high)) begin
			tempo_num = ihte_pkg::NUM_DOUBLE_Q8;
		end else if (PROD_W'(ihte_pkg::MS_PER_MIN) > p_ceil) begin
			tempo_num = ihte_pkg::NUM_HALF_Q8;
		end else begin
			tempo_num = ihte_pkg::NUM_BASE_Q8;
		end
		set_ok    = (count_q == ihte_pkg::COUNT_FULL) && any_q;
		slot_free = !out_valid_q || result.ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ihte_pkg::ST_CLEAR: begin
				if (clr_q == BIN_W'(HIST_BINS - 1)) state_d = ihte_pkg::ST_IDLE;
			end
			ihte_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (gap_ok) state_d = ihte_pkg::ST_BIN;
					else if (onset.data.last_onset) state_d = ihte_pkg::ST_DECIDE;
				end
			end
			ihte_pkg::ST_BIN: begin
				state_d = ihte_pkg::ST_ACC;
			end
			ihte_pkg::ST_ACC: begin
				if (tap_q == ihte_pkg::TAP_LAST) state_d = ihte_pkg::ST_ACC_END;
			end
			ihte_pkg::ST_ACC_END: begin
				state_d = last_q ? ihte_pkg::ST_DECIDE : ihte_pkg::ST_IDLE;
			end
			ihte_pkg::ST_DECIDE: begin
				state_d = set_ok ? ihte_pkg::ST_DIV_LO : ihte_pkg::ST_EMIT;
			end
			ihte_pkg::ST_DIV_LO: begin
				if (div_stat.done) state_d = ihte_pkg::ST_DIV_HI;
			end
			ihte_pkg::ST_DIV_HI: begin
				if (div_stat.done) state_d = ihte_pkg::ST_SEARCH;
			end
			ihte_pkg::ST_SEARCH: begin
				if (!srch_go) state_d = ihte_pkg::ST_SEARCH_END;
			end
			ihte_pkg::ST_SEARCH_END: begin
				state_d = ihte_pkg::ST_DIV_TEMPO;
			end
			ihte_pkg::ST_DIV_TEMPO: begin
				if (div_stat.done) state_d = ihte_pkg::ST_EMIT;
			end
			ihte_pkg::ST_EMIT: begin
				if (slot_free) state_d = ihte_pkg::ST_CLEAR;
			end
			default: begin
				state_d = ihte_pkg::ST_CLEAR;
			end
		endcase
	end

	// State outputs: handshake, memory ports and divider requests.
	always_comb begin
		mem_re       = 1'b0;
		mem_raddr    = tap_addr[BIN_W-1:0];
		mem_we       = 1'b0;
		mem_waddr    = acc_addr_s1;
		mem_wdata    = sat_sum[ihte_pkg::CNT_W] ? '1 : sat_sum[ihte_pkg::CNT_W-1:0];
		div_start    = 1'b0;
		div_dividend = ihte_pkg::NUM_MS_PER_MIN;
		div_divisor  = lo_bpm;
		onset.ready  = (state_q == ihte_pkg::ST_IDLE);

		// Write-back of the accumulation pipeline.
		if (acc_v_s1) mem_we = 1'b1;

		unique case (state_q)
			ihte_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ihte_pkg::ST_ACC: begin
				mem_re = tap_in;
			end
			ihte_pkg::ST_DECIDE: begin
				div_start = set_ok;
			end
			ihte_pkg::ST_DIV_LO: begin
				div_start   = div_stat.done;
				div_divisor = hi_bpm;
			end
			ihte_pkg::ST_SEARCH: begin
				unique case (ph_q)
					ihte_pkg::PH_SELF: begin
						mem_re    = srch_go;
						mem_raddr = sbin_q[BIN_W-1:0];
					end
					ihte_pkg::PH_HALF: begin
						mem_re    = 1'b1;
						mem_raddr = sbin_q[BIN_W:1];
					end
					ihte_pkg::PH_DOUBLE: begin
						mem_re    = dbl_in;
						mem_raddr = {sbin_q[BIN_W-2:0], 1'b0};
					end
					default: begin
						mem_re = 1'b0;
					end
				endcase
			end
			ihte_pkg::ST_SEARCH_END: begin
				div_start    = 1'b1;
				div_dividend = tempo_num;
				div_divisor  = b_eff;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// Shared divider for both period limits and the final tempo.
	ihte_div #(
		.DEN_W (BIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// Histogram memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rd_data_q <= hist_mem[mem_raddr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ihte_pkg::ST_CLEAR;
			min_bpm_q   <= ihte_pkg::MIN_BPM_RST;
			max_bpm_q   <= ihte_pkg::MAX_BPM_RST;
			prev_q      <= '0;
			count_q     <= '0;
			any_q       <= 1'b0;
			last_q      <= 1'b0;
			clr_q       <= '0;
			tap_q       <= '0;
			ph_q        <= ihte_pkg::PH_SELF;
			acc_v_s1    <= 1'b0;
			srch_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Configuration writes.
			if (cfg_wr_en) begin
				unique case (cfg_index)
					ihte_pkg::CFG_MIN_BPM: min_bpm_q <= cfg_data;
					ihte_pkg::CFG_MAX_BPM: max_bpm_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// Onset bookkeeping at each accepted word.
			if (in_acc) begin
				prev_q <= onset.data.onset_time_us;
				last_q <= onset.data.last_onset;
				if (count_q != ihte_pkg::COUNT_FULL) count_q <= count_q + 1'b1;
				if (gap_ok) any_q <= 1'b1;
			end

			// Clearing pass counter.
			if (state_q == ihte_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;

			// Tap counter for the accumulation.
			if (state_q == ihte_pkg::ST_ACC) tap_q <= tap_q + 1'b1;
			else tap_q <= '0;

			// Search read phase.
			if (state_q == ihte_pkg::ST_SEARCH && srch_go) begin
				unique case (ph_q)
					ihte_pkg::PH_SELF:   ph_q <= ihte_pkg::PH_HALF;
					ihte_pkg::PH_HALF:   ph_q <= ihte_pkg::PH_DOUBLE;
					ihte_pkg::PH_DOUBLE: ph_q <= ihte_pkg::PH_SELF;
					default:             ph_q <= ihte_pkg::PH_SELF;
				endcase
			end else begin
				ph_q <= ihte_pkg::PH_SELF;
			end

			// Pipeline valid flags, aligned with the registered read data.
			acc_v_s1  <= (state_q == ihte_pkg::ST_ACC) && tap_in;
			srch_v_s1 <= (state_q == ihte_pkg::ST_SEARCH) && srch_go;

			// Output register and end of set.
			if (state_q == ihte_pkg::ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
				prev_q      <= '0;
				count_q     <= '0;
				any_q       <= 1'b0;
				clr_q       <= '0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) gap_q <= gap_full[ihte_pkg::GAP_W-1:0];

		if (state_q == ihte_pkg::ST_BIN) begin
			bin_q <= BIN_W'(ms_prod[ihte_pkg::RECIP_SHIFT +: ihte_pkg::MS_W]);
		end

		// Accumulation pipeline stage.
		acc_addr_s1 <= tap_addr[BIN_W-1:0];
		acc_w_s1    <= tap_weight(tap_q);

		// Search pipeline stage.
		srch_ph_s1  <= ph_q;
		srch_use_s1 <= (ph_q != ihte_pkg::PH_DOUBLE) || dbl_in;
		srch_bin_s1 <= sbin_q[BIN_W-1:0];

		// Status for sets that give no estimate.
		if (state_q == ihte_pkg::ST_DECIDE) begin
			res_tempo_q <= '0;
			if (count_q != ihte_pkg::COUNT_FULL) res_status_q <= ihte_pkg::STATUS_FEW_ONSETS;
			else res_status_q <= ihte_pkg::STATUS_NO_INTERVAL;
		end

		// Period limits from the divider.
		if (state_q == ihte_pkg::ST_DIV_LO && div_stat.done) begin
			sbin_q <= div_quo[ihte_pkg::SBIN_W-1:0];
		end
		if (state_q == ihte_pkg::ST_DIV_HI && div_stat.done) begin
			stop_q       <= div_quo[ihte_pkg::SBIN_W-1:0];
			best_score_q <= '0;
			best_bin_q   <= '0;
		end

		// Step to the next candidate after its third read.
		if (state_q == ihte_pkg::ST_SEARCH && ph_q == ihte_pkg::PH_DOUBLE) begin
			sbin_q <= sbin_q + 1'b1;
		end

		// Score accumulation; the first highest score wins.
		if (srch_v_s1) begin
			unique case (srch_ph_s1)
				ihte_pkg::PH_SELF:   acc_q <= ihte_pkg::SCORE_W'(rd_data_q);
				ihte_pkg::PH_HALF:   acc_q <= acc_q + half_rd;
				ihte_pkg::PH_DOUBLE: begin
					if (score > best_score_q) begin
						best_score_q <= score;
						best_bin_q   <= srch_bin_s1;
					end
				end
				default: acc_q <= acc_q;
			endcase
		end

		// Final tempo.
		if (state_q == ihte_pkg::ST_DIV_TEMPO && div_stat.done) begin
			res_tempo_q  <= div_quo[ihte_pkg::TEMPO_W-1:0];
			res_status_q <= ihte_pkg::STATUS_OK;
		end

		if (state_q == ihte_pkg::ST_EMIT && slot_free) begin
			out_word_q.tempo_bpm_q8 <= res_tempo_q;
			out_word_q.status       <= res_status_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

endmodule

`default_nettype wire

>>> rtl/core/ihte_checker.sv
// Port-level checks for the tempo estimator, attached by a bind statement.
// Depends on ihte_pkg for the status codes.
`default_nettype none

module ihte_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_ready,
	input wire                                 in_last,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire [ihte_pkg::TEMPO_W-1:0]         out_tempo,
	input wire [ihte_pkg::STATUS_W-1:0]        out_status
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_tempo) && $stable(out_status))
		else $error("result word changed while stalled");

	// A set that fails its checks reports no tempo.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ihte_pkg::STATUS_OK |-> out_tempo == '0)
		else $error("nonzero tempo with failure status");

	// A good estimate is never zero.
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ihte_pkg::STATUS_OK |-> out_tempo != '0)
		else $error("zero tempo with ok status");

	// The last word of a set closes the input until its result is worked out.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("word accepted right after a last word");

	// Reset holds both channels quiet.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_ready)
		else $error("channel active during reset");

endmodule

bind interval_histogram_tempo_estimator_unit ihte_checker u_ihte_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (onset.valid),
	.in_ready   (onset.ready),
	.in_last    (onset.data.last_onset),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_tempo  (result.data.tempo_bpm_q8),
	.out_status (result.data.status)
);

`default_nettype wire

>>> sim/interval_histogram_tempo_estimator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for interval_histogram_tempo_estimator_unit.
// Needs ihte_pkg, ihte_stream_if and the block's RTL; a scoreboard class predicts each
// tempo word from the accepted onset words and checks the block's results in order.

// Tracks the onset histogram and the tempo limits, and holds the tempo words still due.
class tempo_scoreboard;
	bit [15:0] interval_counts [ihte_pkg::HIST_BINS_DEF];
	bit [31:0] previous_onset;
	int unsigned onsets_seen;
	bit gap_seen;
	bit [ihte_pkg::BPM_W-1:0] min_bpm;
	bit [ihte_pkg::BPM_W-1:0] max_bpm;
	ihte_pkg::tempo_word_t expected_tempos[$];
	int mismatches;

	function new();
		restart_set();
		min_bpm = ihte_pkg::MIN_BPM_RST;
		max_bpm = ihte_pkg::MAX_BPM_RST;
		mismatches = 0;
	endfunction

	function void restart_set();
		foreach (interval_counts[i])
			interval_counts[i] = '0;
		previous_onset = '0;
		onsets_seen = 0;
		gap_seen = 1'b0;
	endfunction

	// One gap adds 10 at its millisecond bin and 2 less per bin outward, down to 2 at 4 away.
	function void spread_gap(bit [31:0] gap_us);
		int centre;
		int bin;
		int unsigned sum;
		centre = gap_us / 1000;
		for (int d = -5; d <= 5; d++) begin
			bin = centre + d;
			if (bin >= 0 && bin < ihte_pkg::HIST_BINS_DEF) begin
				sum = interval_counts[bin] + 10 - 2 * (d < 0 ? -d : d);
				interval_counts[bin] = (sum > 16'hFFFF) ? 16'hFFFF : sum[15:0];
			end
		end
	endfunction

	// Scores each period bin in the searched range and converts the best one to Q8 BPM.
	function bit [ihte_pkg::TEMPO_W-1:0] estimate_tempo_q8();
		int unsigned fastest;
		int unsigned slowest;
		int unsigned bin;
		int unsigned score;
		int unsigned best_bin;
		int unsigned best_score;
		int unsigned numerator;
		longint unsigned q8;
		fastest = (max_bpm != 0) ? max_bpm : 1;
		slowest = (min_bpm != 0) ? min_bpm : 1;
		best_bin = 0;
		best_score = 0;
		for (bin = ihte_pkg::MS_PER_MIN / fastest;
		     bin < ihte_pkg::MS_PER_MIN / slowest && bin < ihte_pkg::HIST_BINS_DEF; bin++) begin
			score = interval_counts[bin] + interval_counts[bin / 2] / 2;
			if (bin * 2 < ihte_pkg::HIST_BINS_DEF)
				score += interval_counts[bin * 2] / 2;
			if (score > best_score) begin
				best_score = score;
				best_bin = bin;
			end
		end
		// An empty search falls back to a one millisecond period.
		if (best_bin == 0)
			best_bin = 1;
		numerator = ihte_pkg::MS_PER_MIN;
		if (ihte_pkg::MS_PER_MIN >= ihte_pkg::HALF_TIME_LOW * best_bin &&
		    ihte_pkg::MS_PER_MIN <= ihte_pkg::HALF_TIME_HIGH * best_bin)
			numerator = 2 * ihte_pkg::MS_PER_MIN;
		else if (ihte_pkg::MS_PER_MIN > ihte_pkg::BPM_CEILING * best_bin)
			numerator = ihte_pkg::MS_PER_MIN / 2;
		q8 = (longint'(numerator) * 256) / best_bin;
		return q8[ihte_pkg::TEMPO_W-1:0];
	endfunction

	// Updates the histogram for an accepted onset word; a last word yields one tempo word.
	function void note_onset(ihte_pkg::onset_word_t word);
		bit [31:0] gap_us;
		ihte_pkg::tempo_word_t want;
		if (onsets_seen > 0 && word.onset_time_us >= previous_onset) begin
			gap_us = word.onset_time_us - previous_onset;
			if (gap_us > ihte_pkg::GAP_LOW_US && gap_us < ihte_pkg::GAP_HIGH_US) begin
				spread_gap(gap_us);
				gap_seen = 1'b1;
			end
		end
		previous_onset = word.onset_time_us;
		if (onsets_seen < ihte_pkg::COUNT_FULL)
			onsets_seen++;
		if (!word.last_onset)
			return;
		want.tempo_bpm_q8 = '0;
		if (onsets_seen < ihte_pkg::COUNT_FULL)
			want.status = ihte_pkg::STATUS_FEW_ONSETS;
		else if (!gap_seen)
			want.status = ihte_pkg::STATUS_NO_INTERVAL;
		else begin
			want.status = ihte_pkg::STATUS_OK;
			want.tempo_bpm_q8 = estimate_tempo_q8();
		end
		expected_tempos = {expected_tempos, want};
		restart_set();
	endfunction

	function void report_mismatch(string what, ihte_pkg::tempo_word_t want,
	                              ihte_pkg::tempo_word_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected q8=%0d status=%0d, got q8=%0d status=%0d", $time, what,
			         want.tempo_bpm_q8, want.status, got.tempo_bpm_q8, got.status);
	endfunction

	// Compares an accepted result word with the oldest tempo word due.
	function void check_tempo(ihte_pkg::tempo_word_t got);
		ihte_pkg::tempo_word_t want;
		if (expected_tempos.size() == 0) begin
			want = '0;
			report_mismatch("result with none due", want, got);
			return;
		end
		want = expected_tempos.pop_front();
		if (got.tempo_bpm_q8 !== want.tempo_bpm_q8 || got.status !== want.status)
			report_mismatch("tempo mismatch", want, got);
	endfunction
endclass

module interval_histogram_tempo_estimator_unit_test;

	localparam int HIST_BINS = ihte_pkg::HIST_BINS_DEF;
	// Clearing pass after each result plus a margin.
	localparam int SETTLE_CYCLES = HIST_BINS + 300;
	localparam int ITEMS_PER_PHASE = 125;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [ihte_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ihte_pkg::BPM_W-1:0] cfg_data;
	bit steady_feed;

	ihte_stream_if #(.word_t(ihte_pkg::onset_word_t)) onset_ch ();
	ihte_stream_if #(.word_t(ihte_pkg::tempo_word_t)) result_ch ();

	tempo_scoreboard sb = new();

	interval_histogram_tempo_estimator_unit #(
		.HIST_BINS(HIST_BINS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.onset(onset_ch),
		.result(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#200_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Both handshakes are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (onset_ch.valid && onset_ch.ready)
				sb.note_onset(onset_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.check_tempo(result_ch.data);
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The result receiver stalls at random, with stretches of steady ready.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			stall = idle_length();
			if (stall != 0) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 40)) @(negedge clk);
		end
	end

	// Presents one onset word and returns at the edge that accepts it.
	task automatic send_onset(input bit [31:0] t, input bit last);
		int gap;
		gap = steady_feed ? 0 : idle_length();
		if (gap != 0) begin
			@(negedge clk);
			onset_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		onset_ch.valid <= 1'b1;
		onset_ch.data <= {t, last};
		do @(posedge clk); while (!onset_ch.ready);
	endtask

	task automatic send_steady_set(input bit [31:0] start, input bit [31:0] step,
	                               input int count);
		for (int i = 0; i < count; i++)
			send_onset(start + i * step, i == count - 1);
	endtask

	// Waits until every tempo word due has arrived and the clearing pass is over.
	task automatic drain_and_settle();
		@(negedge clk);
		onset_ch.valid <= 1'b0;
		while (sb.expected_tempos.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_tempo_limits(input bit [ihte_pkg::BPM_W-1:0] slowest,
	                                input bit [ihte_pkg::BPM_W-1:0] fastest);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= ihte_pkg::CFG_MIN_BPM;
		cfg_data <= slowest;
		@(negedge clk);
		cfg_index <= ihte_pkg::CFG_MAX_BPM;
		cfg_data <= fastest;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.min_bpm = slowest;
		sb.max_bpm = fastest;
	endtask

	// One random onset set: mostly a jittered beat in the searched range with the odd
	// skipped beat, short gap, step back or wild jump; also short sets, sets with no
	// usable gap, and pure noise.
	task automatic random_set(output int count);
		int kind;
		int r;
		int shortest;
		int longest;
		int period_ms;
		bit [31:0] t;
		kind = $urandom_range(0, 99);
		steady_feed = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 9);
		if (r == 0)
			t = $urandom();
		else if (r == 1)
			t = 32'hFF00_0000 | $urandom_range(0, 32'h00FF_FFFF);
		else
			t = $urandom_range(0, 32'hE000_0000);
		shortest = ihte_pkg::MS_PER_MIN / ((sb.max_bpm != 0) ? sb.max_bpm : 1);
		longest = ihte_pkg::MS_PER_MIN / ((sb.min_bpm != 0) ? sb.min_bpm : 1) - 1;
		if (shortest < 201)
			shortest = 201;
		if (longest > 1999)
			longest = 1999;
		if (shortest > longest || $urandom_range(0, 4) == 0) begin
			shortest = 201;
			longest = 1999;
		end
		period_ms = $urandom_range(shortest, longest);
		if (kind < 70)
			count = $urandom_range(4, 16);
		else if (kind < 80)
			count = $urandom_range(1, 3);
		else
			count = $urandom_range(4, 10);
		for (int i = 0; i < count; i++) begin
			send_onset(t, i == count - 1);
			r = $urandom_range(0, 19);
			if (kind >= 90)
				t = $urandom();
			else if (kind >= 80) begin
				case (r % 4)
					0: t = t + $urandom_range(0, 200_000);
					1: t = t + 2_000_000;
					2: t = t + $urandom_range(2_000_000, 32'h7FFF_FFFF);
					default: t = t - $urandom_range(1, 1_000_000);
				endcase
			end else if (r == 0)
				t = t + period_ms * 2000;
			else if (r == 1)
				t = t + $urandom_range(0, 200_000);
			else if (r == 2)
				t = t - $urandom_range(1, 2_000_000);
			else if (r == 3)
				t = t + $urandom();
			else
				t = t + period_ms * 1000 + $urandom_range(0, 30_000) - 15_000;
		end
	endtask

	initial begin
		bit [ihte_pkg::BPM_W-1:0] phase_min [6];
		bit [ihte_pkg::BPM_W-1:0] phase_max [6];
		bit [ihte_pkg::BPM_W-1:0] slowest;
		int items;
		int count;
		phase_min = '{9'd60, 9'd1, 9'd0, 9'd511, 9'd240, 9'd120};
		phase_max = '{9'd200, 9'd300, 9'd511, 9'd0, 9'd250, 9'd180};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = ihte_pkg::CFG_MIN_BPM;
		cfg_data = '0;
		onset_ch.valid = 1'b0;
		onset_ch.data = '0;
		steady_feed = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset limits: a lone onset, then a set whose gaps sit on the window edges,
		// step back or repeat, so none is usable.
		send_onset(32'd0, 1'b1);
		send_onset(32'd5_000_000, 1'b0);
		send_onset(32'd5_200_000, 1'b0);
		send_onset(32'd7_200_000, 1'b0);
		send_onset(32'd7_000_000, 1'b0);
		send_onset(32'd7_000_000, 1'b1);
		// Shortest and longest usable gaps.
		send_onset(32'h1000_0000, 1'b0);
		send_onset(32'h1000_0000 + 32'd200_001, 1'b0);
		send_onset(32'h1000_0000 + 32'd2_200_000, 1'b0);
		send_onset(32'h1000_0000 + 32'd2_700_000, 1'b0);
		send_onset(32'h1000_0000 + 32'd3_200_000, 1'b1);
		// Times at the top of the range, then a lone onset at the largest time.
		send_steady_set(32'hFFC0_0000, 32'd600_000, 4);
		send_onset(32'hFFFF_FFFF, 1'b1);
		// A 65 BPM beat is reported doubled.
		send_steady_set(32'd40_000_000, 32'd923_000, 4);

		// Zero and all-ones limits; a 240 BPM beat is reported halved.
		drain_and_settle();
		set_tempo_limits(9'd0, 9'd511);
		send_steady_set(32'd1_000, 32'd250_000, 4);
		// Inverted limits leave nothing to search.
		drain_and_settle();
		set_tempo_limits(9'd300, 9'd1);
		send_steady_set(32'h8000_0000, 32'd700_000, 4);
		// A long steady beat builds a large count in the center bin.
		drain_and_settle();
		set_tempo_limits(ihte_pkg::MIN_BPM_RST, ihte_pkg::MAX_BPM_RST);
		steady_feed = 1'b1;
		send_steady_set(32'd0, 32'd500_000, 120);
		steady_feed = 1'b0;

		// Random sets under a series of tempo limits, the last one random.
		for (int phase = 0; phase < 7; phase++) begin
			drain_and_settle();
			if (phase < 6)
				set_tempo_limits(phase_min[phase], phase_max[phase]);
			else begin
				slowest = ihte_pkg::BPM_W'($urandom_range(20, 150));
				set_tempo_limits(slowest, ihte_pkg::BPM_W'($urandom_range(slowest, 300)));
			end
			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				random_set(count);
				items += count;
			end
		end
		drain_and_settle();

		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

>>> interval_histogram_tempo_estimator_unit.f
rtl/core/ihte_pkg.sv
rtl/core/ihte_stream_if.sv
rtl/core/ihte_div.sv
rtl/core/interval_histogram_tempo_estimator_unit.sv
rtl/core/ihte_checker.sv
sim/interval_histogram_tempo_estimator_unit_test.sv
